// File: hdl/bpm_pkg.sv
// ----------------------------------------------------------------------------
// Block peak / RMS meter package
// Shared payload types, widths, controller states and command/status structs.
// ----------------------------------------------------------------------------
package bpm_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int COUNT_OUT_W   = 10;
    localparam int PEAK_OUT_W    = 16;
    localparam int RMS_OUT_W     = 20;
    localparam int MAG_W         = 17;
    localparam int SQUARE_W      = 31;
    localparam int FRAC_SHIFT    = 8;
    localparam int MEAN_W        = 39;
    localparam int ROOT_W        = 20;
    localparam int RAD_W         = 2 * ROOT_W;
    localparam int SREM_W        = ROOT_W + 3;
    localparam int SQ_CNT_W      = $clog2(ROOT_W);
    localparam int BLOCK_MAX_DEF = 512;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } s_payload_t;

    typedef struct packed {
        logic [COUNT_OUT_W-1:0] blk_count;
        logic [PEAK_OUT_W-1:0]  peak_level;
        logic [RMS_OUT_W-1:0]   rms_level;
    } m_payload_t;

    typedef enum logic [1:0] {
        ST_ACC,
        ST_DIV,
        ST_SQRT,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic take;
        logic div_step;
        logic sqrt_load;
        logic sqrt_step;
        logic out_load;
    } ctl_cmd_t;

    typedef struct packed {
        logic close;
        logic div_done;
        logic sqrt_done;
        logic out_free;
    } ctl_status_t;

endpackage

// File: hdl/block_peak_rms_meter.sv
// ----------------------------------------------------------------------------
// Block peak / RMS meter top level
// Per-block peak, sample count and RMS (4 fraction bits) of a PCM stream.
// ----------------------------------------------------------------------------
// Throughput: one sample per cycle inside a block.
// The closing sample starts a serial divide and a serial root; no sample is
// taken until the result is loaded.
// The result is loaded into the output register after the root, once the
// output is free. Reset (aresetn low, synchronous) clears the accumulators,
// the controller and the result valid.
module block_peak_rms_meter #(
    parameter int BLOCK_MAX = bpm_pkg::BLOCK_MAX_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bpm_pkg::s_payload_t s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output bpm_pkg::m_payload_t m_payload
);
    import bpm_pkg::*;

    ctl_cmd_t    cmd;
    ctl_status_t status;

    bpm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    bpm_datapath #(
        .BLOCK_MAX (BLOCK_MAX)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .m_payload (m_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// File: hdl/bpm_ctrl.sv
// ----------------------------------------------------------------------------
// Block peak / RMS meter controller
// Sequences accumulation, the serial divide, the serial root and result load.
// ----------------------------------------------------------------------------
module bpm_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  bpm_pkg::ctl_status_t status,
    output bpm_pkg::ctl_cmd_t    cmd
);
    import bpm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACC;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_ACC: begin
                if (s_valid && status.close) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (status.sqrt_done) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (status.out_free) begin
                    state_next = ST_ACC;
                end
            end
            default: begin
                state_next = ST_ACC;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_ACC: begin
                s_ready  = 1'b1;
                cmd.take = s_valid;
            end
            ST_DIV: begin
                cmd.div_step  = 1'b1;
                cmd.sqrt_load = status.div_done;
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
            end
            ST_HOLD: begin
                cmd.out_load = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: hdl/bpm_datapath.sv
// ----------------------------------------------------------------------------
// Block peak / RMS meter datapath
// Accumulators, radix-2 restoring divider, digit-by-digit root, result register.
// ----------------------------------------------------------------------------
module bpm_datapath #(
    parameter int BLOCK_MAX = bpm_pkg::BLOCK_MAX_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  bpm_pkg::s_payload_t  s_payload,
    output bpm_pkg::m_payload_t  m_payload,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  bpm_pkg::ctl_cmd_t    cmd,
    output bpm_pkg::ctl_status_t status
);
    import bpm_pkg::*;

    localparam int CNT_W  = $clog2(BLOCK_MAX + 1);
    localparam int SUM_W  = SQUARE_W + CNT_W;
    localparam int NUM_W  = SUM_W + FRAC_SHIFT;
    localparam int DCNT_W = $clog2(NUM_W);

    logic [MAG_W-1:0]    mag;
    logic [2*MAG_W-1:0]  square_full;
    logic [MAG_W-1:0]    peak_next;
    logic [SUM_W-1:0]    sum_next;
    logic [CNT_W-1:0]    count_next;

    logic [MAG_W-1:0]    peak_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [MAG_W-1:0]    snap_peak_reg;
    logic [CNT_W-1:0]    snap_count_reg;

    logic [NUM_W-1:0]    quo_reg;
    logic [NUM_W-1:0]    quo_next;
    logic [CNT_W-1:0]    rem_reg;
    logic [CNT_W-1:0]    rem_next;
    logic [CNT_W:0]      div_trial;
    logic [CNT_W:0]      div_diff;
    logic                div_ge;
    logic [DCNT_W-1:0]   div_cnt_reg;

    logic [RAD_W-1:0]    rad_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [ROOT_W-1:0]   root_next;
    logic [SREM_W-1:0]   srem_reg;
    logic [SREM_W-1:0]   srem_next;
    logic [SREM_W-1:0]   srem_sh;
    logic [SREM_W-1:0]   sqrt_trial;
    logic                sqrt_ge;
    logic [SQ_CNT_W-1:0] sq_cnt_reg;

    m_payload_t          m_payload_reg;
    logic                m_valid_reg;

    assign mag = s_payload.sample[SAMPLE_W-1]
               ? (MAG_W'(17'h10000) - {1'b0, s_payload.sample})
               : {1'b0, s_payload.sample};
    assign square_full = mag * mag;
    assign peak_next   = (mag > peak_reg) ? mag : peak_reg;
    assign sum_next    = sum_reg + SUM_W'(square_full[SQUARE_W-1:0]);
    assign count_next  = count_reg + 1'b1;

    assign div_trial = {rem_reg, quo_reg[NUM_W-1]};
    assign div_ge    = div_trial >= {1'b0, snap_count_reg};
    assign div_diff  = div_trial - {1'b0, snap_count_reg};
    assign rem_next  = div_ge ? div_diff[CNT_W-1:0] : div_trial[CNT_W-1:0];
    assign quo_next  = {quo_reg[NUM_W-2:0], div_ge};

    assign srem_sh    = {srem_reg[SREM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign sqrt_trial = {1'b0, root_reg, 2'b01};
    assign sqrt_ge    = srem_sh >= sqrt_trial;
    assign srem_next  = sqrt_ge ? (srem_sh - sqrt_trial) : srem_sh;
    assign root_next  = {root_reg[ROOT_W-2:0], sqrt_ge};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_reg  <= '0;
            sum_reg   <= '0;
            count_reg <= '0;
        end else if (cmd.take) begin
            if (status.close) begin
                peak_reg  <= '0;
                sum_reg   <= '0;
                count_reg <= '0;
            end else begin
                peak_reg  <= peak_next;
                sum_reg   <= sum_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take && status.close) begin
            snap_peak_reg  <= peak_next;
            snap_count_reg <= count_next;
            quo_reg        <= {sum_next, {FRAC_SHIFT{1'b0}}};
            rem_reg        <= '0;
            div_cnt_reg    <= '0;
        end else if (cmd.div_step) begin
            quo_reg     <= quo_next;
            rem_reg     <= rem_next;
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sqrt_load) begin
            rad_reg    <= RAD_W'(quo_next[MEAN_W-1:0]);
            root_reg   <= '0;
            srem_reg   <= '0;
            sq_cnt_reg <= '0;
        end else if (cmd.sqrt_step) begin
            rad_reg    <= {rad_reg[RAD_W-3:0], 2'b00};
            root_reg   <= root_next;
            srem_reg   <= srem_next;
            sq_cnt_reg <= sq_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_payload_reg.blk_count  <= COUNT_OUT_W'(snap_count_reg);
            m_payload_reg.peak_level <= snap_peak_reg[PEAK_OUT_W-1:0];
            m_payload_reg.rms_level  <= root_reg;
        end
    end

    assign status.close     = s_payload.last || (count_reg == CNT_W'(BLOCK_MAX - 1));
    assign status.div_done  = div_cnt_reg == DCNT_W'(NUM_W - 1);
    assign status.sqrt_done = sq_cnt_reg == SQ_CNT_W'(ROOT_W - 1);
    assign status.out_free  = !m_valid_reg || m_ready;

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

// File: hdl/bpm_checker.sv
// ----------------------------------------------------------------------------
// Block peak / RMS meter checker
// Port-level properties of the meter, bound to the top level.
// ----------------------------------------------------------------------------
module bpm_checker #(
    parameter int BLOCK_MAX = bpm_pkg::BLOCK_MAX_DEF
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input bpm_pkg::s_payload_t s_payload,
    input logic                m_valid,
    input logic                m_ready,
    input bpm_pkg::m_payload_t m_payload
);
    import bpm_pkg::*;

    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("stalled result changed");

    a_close_stalls_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_payload.last |=> !s_ready)
        else $error("input taken while block result is computed");

    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_payload.blk_count != '0 || BLOCK_MAX >= (1 << COUNT_OUT_W))
        else $error("result with empty block");

    a_rms_below_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_payload.rms_level[RMS_OUT_W-1:4] <= m_payload.peak_level)
        else $error("rms above peak");

endmodule

bind block_peak_rms_meter bpm_checker #(.BLOCK_MAX(BLOCK_MAX)) u_bpm_checker (.*);
